// ===== rtl/core/ist_pkg.sv =====
package ist_pkg;

    localparam int IST_CAPACITY = 16;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;
    localparam logic [2:0] ST_FOUND    = 3'd5;
    localparam logic [2:0] ST_NOTFOUND = 3'd6;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } ist_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] member_count;
        logic       is_empty;
    } ist_rsp_t;

    typedef struct packed {
        logic shift;
        logic write;
    } ist_cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } ist_state_t;

endpackage

// ===== rtl/core/integer_set_table_core.sv =====
// A set of up to CAPACITY distinct 32-bit integers held in a packed row of cells.
// Each request has a compare step and an apply step: in the compare step, every
// cell compares its entry with the value in parallel and the result is decided;
// in the apply step, the row appends or shifts down by one place while the next
// request may already be accepted, so busy is high for one cycle per beat and a
// new beat can start before the last is applied. The result is shown with done
// for exactly one cycle, in the cycle after busy; the receiver cannot stall it.
module integer_set_table_core
    import ist_pkg::*;
#(
    parameter int CAPACITY = IST_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  ist_req_t request,
    output logic     done,
    output ist_rsp_t result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    ist_state_t         state_reg;
    ist_state_t         state_next;
    logic [1:0]         cmd_reg;
    logic [31:0]        value_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    ist_cell_ctrl_t     ctrl_reg;
    ist_cell_ctrl_t     ctrl_next;
    ist_rsp_t           result_reg;
    ist_rsp_t           result_next;
    logic               done_reg;

    logic [CAPACITY-1:0] match;
    logic [31:0]         entry    [CAPACITY];
    logic [31:0]         upper    [CAPACITY];
    logic                hit;
    logic [IDX_W-1:0]    hit_pos;
    logic [2:0]          status;
    logic                accept;

    assign busy   = (state_reg == S_CMP);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_last
            assign upper[i] = entry[i];
        end
        else
        begin : g_inner
            assign upper[i] = entry[i+1];
        end

        ist_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl_reg),
            .pos         (pos_reg),
            .count       (count_reg),
            .value       (value_reg),
            .upper_entry (upper[i]),
            .entry       (entry[i]),
            .match       (match[i])
        );
    end

    // Entries are distinct, so at most one cell matches and an OR encoder finds it.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
        hit = |match;
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        ctrl_next  = '0;
        status     = ST_NOTFOUND;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (hit)
                begin
                    status = ST_PRESENT;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status          = ST_ADDED;
                    count_next      = count_reg + 1'b1;
                    pos_next        = count_reg[IDX_W-1:0];
                    ctrl_next.write = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    status          = ST_REMOVED;
                    count_next      = count_reg - 1'b1;
                    pos_next        = hit_pos;
                    ctrl_next.shift = 1'b1;
                end
                else
                begin
                    status = ST_ABSENT;
                end
            end
            default:
            begin
                status = hit ? ST_FOUND : ST_NOTFOUND;
            end
        endcase
        result_next.status       = status;
        result_next.member_count = 5'(count_next);
        result_next.is_empty     = (count_next == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: state_next = accept ? S_CMP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ctrl_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= busy;
            if (busy)
            begin
                count_reg <= count_next;
                ctrl_reg  <= ctrl_next;
            end
            else
            begin
                ctrl_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= request.command;
            value_reg <= request.value;
        end
        if (busy)
        begin
            pos_reg    <= pos_next;
            result_reg <= result_next;
        end
    end

endmodule

// ===== rtl/core/ist_cell.sv =====
module ist_cell
    import ist_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
)
(
    input  logic               clk,
    input  ist_cell_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]   pos,
    input  logic [CNT_W-1:0]   count,
    input  logic [31:0]        value,
    input  logic [31:0]        upper_entry,
    output logic [31:0]        entry,
    output logic               match
);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;

    assign entry = entry_reg;
    assign match = (entry_reg == value) && (CNT_W'(IDX) < count);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift && (IDX_W'(IDX) >= pos))
        begin
            entry_next = upper_entry;
        end
        else if (ctrl.write && (IDX_W'(IDX) == pos))
        begin
            entry_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/core/ist_checker.sv =====
module ist_checker
    import ist_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input ist_req_t request,
    input logic     done,
    input ist_rsp_t result
);

    // Every accepted beat is worked on in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted beat did not make the core busy");

    // The result follows the busy cycle directly and is shown once.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> (done && !busy))
        else $error("result did not follow the busy cycle");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // An empty set always reports a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.member_count == 5'd0))
        else $error("empty flag with a nonzero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= ST_NOTFOUND))
        else $error("undefined status code");

endmodule

bind integer_set_table_core ist_checker u_ist_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

// ===== verif/integer_set_table_checker.sv =====
module integer_set_table_checker
    import ist_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  ist_req_t request,
    input  logic     done,
    input  ist_rsp_t result,
    output int       fail_count,
    output int       pending_count,
    output int       checked_count
);

    localparam int PRINT_LIMIT = 40;

    logic signed [31:0] member_values [IST_CAPACITY];
    int                 member_total = 0;
    ist_rsp_t           expected_rsp [$];
    ist_rsp_t           oldest_rsp;
    int                 mismatches = 0;
    int                 compared = 0;

    function automatic ist_rsp_t apply_set_request(ist_req_t req);
        int       slot;
        int       i;
        ist_rsp_t rsp;
        slot = member_total;
        for (i = member_total - 1; i >= 0; i--)
        begin
            if (member_values[i] == req.value)
                slot = i;
        end
        case (req.command)
            CMD_ADD:
            begin
                if (slot < member_total)
                    rsp.status = ST_PRESENT;
                else if (member_total >= IST_CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    member_values[member_total] = req.value;
                    member_total++;
                    rsp.status = ST_ADDED;
                end
            end
            CMD_REMOVE:
            begin
                if (slot < member_total)
                begin
                    for (i = slot; i + 1 < member_total; i++)
                        member_values[i] = member_values[i + 1];
                    member_total--;
                    rsp.status = ST_REMOVED;
                end
                else
                    rsp.status = ST_ABSENT;
            end
            default:
            begin
                rsp.status = (slot < member_total) ? ST_FOUND : ST_NOTFOUND;
            end
        endcase
        rsp.member_count = 5'(member_total);
        rsp.is_empty     = (member_total == 0);
        return rsp;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH on response %0d: %s is %0d, expected %0d",
                     compared, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                    flag_mismatch("unrequested response status", int'(result.status), 0);
                else
                begin
                    oldest_rsp = expected_rsp.pop_front();
                    if (result.status !== oldest_rsp.status)
                        flag_mismatch("status", int'(result.status),
                                      int'(oldest_rsp.status));
                    if (result.member_count !== oldest_rsp.member_count)
                        flag_mismatch("member_count", int'(result.member_count),
                                      int'(oldest_rsp.member_count));
                    if (result.is_empty !== oldest_rsp.is_empty)
                        flag_mismatch("is_empty", int'(result.is_empty),
                                      int'(oldest_rsp.is_empty));
                    compared++;
                end
            end
            if (start && !busy)
                expected_rsp.push_back(apply_set_request(request));
        end
        fail_count    <= mismatches;
        pending_count <= expected_rsp.size();
        checked_count <= compared;
    end

endmodule

// ===== verif/integer_set_table_core_tb.sv =====
module integer_set_table_core_tb;
    import ist_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 1000;
    localparam int BLOCK_LEN       = 100;
    localparam int POOL_SIZE       = 20;
    localparam int MAX_GAP         = 17;
    localparam int WATCHDOG_LIMIT  = 400;
    localparam int SETTLE_CYCLES   = 8;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ist_req_t request;
    logic     done;
    ist_rsp_t result;

    int fail_count;
    int pending_count;
    int checked_count;

    int                 sent_count [4];
    int                 idle_cycles;
    logic signed [31:0] value_pool [POOL_SIZE];

    integer_set_table_core DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    integer_set_table_checker CHECK
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d responses pending.", pending_count);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_beat(logic [1:0] cmd, logic signed [31:0] val, int gap);
        ist_req_t beat;
        beat.command = cmd;
        beat.value   = val;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= beat;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count[cmd]++;
    endtask

    initial
    begin
        int                 i;
        int                 n;
        int                 k;
        int                 add_pct;
        int                 pick;
        bit                 burst;
        logic [1:0]         cmd;
        logic signed [31:0] val;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        add_pct = 50;
        burst   = 1'b0;
        foreach (sent_count[j])
            sent_count[j] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(CMD_QUERY, 32'sd5, $urandom_range(0, MAX_GAP));
        send_beat(CMD_REMOVE, 32'sd5, $urandom_range(0, MAX_GAP));
        send_beat(CMD_UNUSED, 32'sd0, $urandom_range(0, MAX_GAP));
        for (i = 0; i < IST_CAPACITY; i++)
        begin
            case (i)
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = 32'sh0000_0000;
                3:       val = 32'shffff_ffff;
                4:       val = 32'sh5555_5555;
                5:       val = 32'shaaaa_aaaa;
                default: val = 32'sh1 << i;
            endcase
            send_beat(CMD_ADD, val, $urandom_range(0, MAX_GAP));
        end
        send_beat(CMD_ADD, 32'sd12345, $urandom_range(0, MAX_GAP));
        send_beat(CMD_ADD, 32'sh7fff_ffff, $urandom_range(0, MAX_GAP));
        send_beat(CMD_UNUSED, 32'shffff_ffff, $urandom_range(0, MAX_GAP));
        send_beat(CMD_REMOVE, 32'sh0000_0000, $urandom_range(0, MAX_GAP));
        send_beat(CMD_REMOVE, 32'sh8000_0000, $urandom_range(0, MAX_GAP));
        send_beat(CMD_REMOVE, 32'sh1 << (IST_CAPACITY - 1), $urandom_range(0, MAX_GAP));
        send_beat(CMD_REMOVE, 32'sh0000_0000, $urandom_range(0, MAX_GAP));

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = 32'shffff_ffff;
        for (i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % BLOCK_LEN == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       add_pct = 75;
                    1:       add_pct = 45;
                    default: add_pct = 20;
                endcase
                burst = ($urandom_range(0, 3) == 0);
                for (k = 0; k < 4; k++)
                    value_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
            end
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
                cmd = CMD_ADD;
            else if (pick < add_pct + (100 - add_pct) / 2)
                cmd = CMD_REMOVE;
            else if ($urandom_range(0, 15) == 0)
                cmd = CMD_UNUSED;
            else
                cmd = CMD_QUERY;
            if ($urandom_range(0, 9) == 0)
                val = $urandom;
            else
                val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_beat(cmd, val, burst ? 0 : $urandom_range(0, MAX_GAP));
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Drove %0d adds, %0d removes, %0d queries and %0d spare-code beats.",
                 sent_count[CMD_ADD], sent_count[CMD_REMOVE], sent_count[CMD_QUERY],
                 sent_count[CMD_UNUSED]);
        $display("Checked %0d responses against the predicted set; %0d mismatches.",
                 checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
